>>> rtl/mce_pkg.sv
// Shared types and constants of the chord expander.
package mce_pkg;

    localparam int NOTE_COUNT_DEF   = 128;
    localparam int CHORD_VOICES_DEF = 8;
    localparam int KEY_W            = 7;
    localparam int STR_W            = 8;
    localparam int CNT_W            = 4;
    localparam int REF_W            = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int OFFS_W           = 48;

    localparam logic [1:0] MODE_ON    = 2'd0;
    localparam logic [1:0] MODE_OFF   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic KIND_ON  = 1'b0;
    localparam logic KIND_OFF = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALES = 3'd4;

    localparam logic [STR_W-1:0] STR_FULL = 8'd128;
    localparam logic [REF_W-1:0] REF_MAX  = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAB_RD,
        S_REL_RD,
        S_REL_WB,
        S_AFTER,
        S_BUILD,
        S_STORE,
        S_ADD_RD,
        S_ADD_WB,
        S_FLUSH
    } state_t;

endpackage

>>> rtl/midi_chord_expander_refcount.sv
// Top level of the chord expander: configuration, sequencer and result staging.
//
// Usage: an item (mode, key, strength) is accepted at a clock edge where start
// is high and busy is low. Modes: note on, note off, clear all tracking.
// Results leave on out_kind, out_key and out_strength, each valid for exactly
// one cycle while result_valid is high; last marks the final result of an item.
// An item may cause no result at all (clear, unused mode, fully held notes).
// Configuration is written through cfg_we, cfg_index and cfg_data, one register
// per edge, by the user only while busy is low; the block does not enforce this.
// Sequence: the sequencer reads the chord table once, then does a
// read-modify-write of the reference count memory per released note and per
// new chord note, and walks the chord slots one per cycle. Clear and the
// unused mode never raise busy. Each result is held back one step so the
// final one can carry last; that one is on the ports in the first cycle after
// busy falls. Reset sets the configuration to its defaults and clears the
// valid bits of both memories, so all tracking and all counts read as zero at
// once. The receiver cannot stall.
module midi_chord_expander_refcount
    import mce_pkg::*;
#(
    parameter int CHORD_VOICES = CHORD_VOICES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [KEY_W-1:0]      key,
    input  logic [STR_W-1:0]      strength,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic                  out_kind,
    output logic [KEY_W-1:0]      out_key,
    output logic [STR_W-1:0]      out_strength,
    output logic                  last
);

    localparam int VW    = (CHORD_VOICES > 1) ? $clog2(CHORD_VOICES) : 1;
    localparam int TAB_W = CNT_W + KEY_W * CHORD_VOICES;
    localparam logic [CNT_W-1:0] VOICES = CNT_W'(CHORD_VOICES);

    // Configuration registers.
    logic                  enable_reg;
    logic [CNT_W-1:0]      limit_reg;
    logic [7:0]            mask_reg;
    logic [OFFS_W-1:0]     offs_reg;
    logic [CFG_DATA_W-1:0] scales_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= CNT_W'(1);
            mask_reg   <= '0;
            offs_reg   <= '0;
            scales_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_LIMIT:  limit_reg  <= cfg_data[CNT_W-1:0];
                REG_MASK:   mask_reg   <= cfg_data[7:0];
                REG_OFFS:   offs_reg   <= cfg_data[OFFS_W-1:0];
                REG_SCALES: scales_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer state.
    state_t               state_reg, state_next;
    logic [1:0]           mode_reg, mode_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [STR_W-1:0]     str_reg, str_next;
    logic                 tracked_reg, tracked_next;
    logic                 any_en_reg, any_en_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     ent_cnt_reg, ent_cnt_next;
    logic [KEY_W-1:0]     ent_keys_reg [CHORD_VOICES];
    logic [KEY_W-1:0]     ent_keys_next [CHORD_VOICES];
    logic [CNT_W-1:0]     ch_cnt_reg, ch_cnt_next;
    logic [KEY_W-1:0]     ch_keys_reg [CHORD_VOICES];
    logic [KEY_W-1:0]     ch_keys_next [CHORD_VOICES];
    logic [STR_W-1:0]     ch_strs_reg [CHORD_VOICES];
    logic [STR_W-1:0]     ch_strs_next [CHORD_VOICES];

    // Result staging: one pending result, so the final one can carry last.
    logic                 pend_reg, pend_next;
    logic                 pend_kind_reg, pend_kind_next;
    logic [KEY_W-1:0]     pend_key_reg, pend_key_next;
    logic [STR_W-1:0]     pend_str_reg, pend_str_next;
    logic                 rv_reg, rv_next;
    logic                 ok_reg, ok_next;
    logic [KEY_W-1:0]     okey_reg, okey_next;
    logic [STR_W-1:0]     ostr_reg, ostr_next;
    logic                 last_reg, last_next;

    // Memory ports.
    logic                 clear_all;
    logic                 tab_we, tab_wvalid, tab_rvalid;
    logic [TAB_W-1:0]     tab_wdata, tab_rdata;
    logic [KEY_W-1:0]     tab_raddr;
    logic                 ref_we, ref_rvalid;
    logic [KEY_W-1:0]     ref_addr;
    logic [REF_W-1:0]     ref_wdata, ref_rdata, ref_val;

    mce_vmem #(.WIDTH(TAB_W), .DEPTH(NOTE_COUNT_DEF)) u_tab (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .we        (tab_we),
        .waddr     (key_reg),
        .wvalid    (tab_wvalid),
        .wdata     (tab_wdata),
        .raddr     (tab_raddr),
        .rdata     (tab_rdata),
        .rvalid    (tab_rvalid)
    );

    mce_vmem #(.WIDTH(REF_W), .DEPTH(NOTE_COUNT_DEF)) u_ref (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .we        (ref_we),
        .waddr     (ref_addr),
        .wvalid    (1'b1),
        .wdata     (ref_wdata),
        .raddr     (ref_addr),
        .rdata     (ref_rdata),
        .rvalid    (ref_rvalid)
    );

    assign ref_val = ref_rvalid ? ref_rdata : '0;

    // Slot arithmetic for the slot under the index.
    logic [CNT_W-1:0]     lim;
    logic [2:0]           slot;
    logic signed [5:0]    off_raw;
    logic signed [8:0]    off_c, note_s;
    logic [KEY_W-1:0]     note;
    logic [STR_W-1:0]     scale;
    logic [15:0]          prod;
    logic [STR_W-1:0]     slot_str;

    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (limit_reg > VOICES)
        begin
            lim = VOICES;
        end
        else
        begin
            lim = limit_reg;
        end
        slot    = idx_reg[2:0];
        off_raw = offs_reg[6*slot +: 6];
        if (off_raw < -6'sd24)
        begin
            off_c = -9'sd24;
        end
        else if (off_raw > 6'sd24)
        begin
            off_c = 9'sd24;
        end
        else
        begin
            off_c = 9'(off_raw);
        end
        note_s = $signed({2'b00, key_reg}) + off_c;
        if (note_s < 0)
        begin
            note = '0;
        end
        else if (note_s > 9'sd127)
        begin
            note = 7'd127;
        end
        else
        begin
            note = note_s[KEY_W-1:0];
        end
        scale = scales_reg[8*slot +: 8];
        if (scale > STR_FULL)
        begin
            scale = STR_FULL;
        end
        prod     = str_reg * scale;
        slot_str = (prod[15:7] > 9'(STR_FULL)) ? STR_FULL : prod[14:7];
    end

    // Candidate note to merge into the chord list in the build state.
    logic                    add_go;
    logic [KEY_W-1:0]        add_key;
    logic [STR_W-1:0]        add_str;
    logic [CHORD_VOICES-1:0] hit;

    always_comb
    begin
        for (int j = 0; j < CHORD_VOICES; j++)
        begin
            hit[j] = (CNT_W'(j) < ch_cnt_reg) && (ch_keys_reg[j] == add_key);
        end
    end

    // Next state, memory control and result generation.
    logic                 emit;
    logic                 emit_kind;
    logic [KEY_W-1:0]     emit_key;
    logic [STR_W-1:0]     emit_str;

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        str_next     = str_reg;
        tracked_next = tracked_reg;
        any_en_next  = any_en_reg;
        idx_next     = idx_reg;
        ent_cnt_next = ent_cnt_reg;
        ent_keys_next = ent_keys_reg;
        ch_cnt_next  = ch_cnt_reg;
        ch_keys_next = ch_keys_reg;
        ch_strs_next = ch_strs_reg;
        clear_all    = 1'b0;
        tab_we       = 1'b0;
        tab_wvalid   = 1'b0;
        tab_raddr    = key;
        ref_we       = 1'b0;
        ref_addr     = ent_keys_reg[idx_reg[VW-1:0]];
        ref_wdata    = ref_val;
        emit         = 1'b0;
        emit_kind    = KIND_OFF;
        emit_key     = key_reg;
        emit_str     = '0;
        add_go       = 1'b0;
        add_key      = note;
        add_str      = slot_str;
        for (int j = 0; j < CHORD_VOICES; j++)
        begin
            tab_wdata[CNT_W + KEY_W*j +: KEY_W] = ch_keys_reg[j];
        end
        tab_wdata[CNT_W-1:0] = ch_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    key_next  = key;
                    str_next  = (strength > STR_FULL) ? STR_FULL : strength;
                    if (mode == MODE_CLEAR)
                    begin
                        clear_all = 1'b1;
                    end
                    else if (mode == MODE_ON || mode == MODE_OFF)
                    begin
                        state_next = S_TAB_RD;
                    end
                end
            end
            S_TAB_RD:
            begin
                tracked_next = tab_rvalid;
                ent_cnt_next = tab_rdata[CNT_W-1:0];
                for (int j = 0; j < CHORD_VOICES; j++)
                begin
                    ent_keys_next[j] = tab_rdata[CNT_W + KEY_W*j +: KEY_W];
                end
                idx_next = '0;
                if (tab_rvalid)
                begin
                    // Release the entry: it is captured now.
                    tab_we     = 1'b1;
                    tab_wvalid = 1'b0;
                    state_next = S_REL_RD;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end
            S_REL_RD:
            begin
                if (idx_reg < ent_cnt_reg && idx_reg < VOICES)
                begin
                    state_next = S_REL_WB;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end
            S_REL_WB:
            begin
                if (ref_val != '0)
                begin
                    ref_we    = 1'b1;
                    ref_wdata = ref_val - REF_W'(1);
                    if (ref_val == REF_W'(1))
                    begin
                        emit     = 1'b1;
                        emit_key = ref_addr;
                    end
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_REL_RD;
            end
            S_AFTER:
            begin
                idx_next    = '0;
                ch_cnt_next = '0;
                any_en_next = 1'b0;
                state_next  = S_FLUSH;
                if (mode_reg == MODE_OFF)
                begin
                    emit = !tracked_reg;
                end
                else if (!enable_reg)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_ON;
                    emit_str  = str_reg;
                end
                else
                begin
                    state_next = S_BUILD;
                end
            end
            S_BUILD:
            begin
                if (idx_reg < lim)
                begin
                    add_go   = mask_reg[slot];
                    idx_next = idx_reg + CNT_W'(1);
                    if (mask_reg[slot])
                    begin
                        any_en_next = 1'b1;
                    end
                end
                else
                begin
                    add_go     = !any_en_reg;
                    add_key    = key_reg;
                    add_str    = str_reg;
                    state_next = S_STORE;
                end
                if (add_go && add_str != '0)
                begin
                    if (hit != '0)
                    begin
                        for (int j = 0; j < CHORD_VOICES; j++)
                        begin
                            if (hit[j] && add_str > ch_strs_reg[j])
                            begin
                                ch_strs_next[j] = add_str;
                            end
                        end
                    end
                    else if (ch_cnt_reg < VOICES)
                    begin
                        ch_keys_next[ch_cnt_reg[VW-1:0]] = add_key;
                        ch_strs_next[ch_cnt_reg[VW-1:0]] = add_str;
                        ch_cnt_next = ch_cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_STORE:
            begin
                idx_next = '0;
                if (ch_cnt_reg != '0)
                begin
                    tab_we     = 1'b1;
                    tab_wvalid = 1'b1;
                    state_next = S_ADD_RD;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_ADD_RD:
            begin
                ref_addr = ch_keys_reg[idx_reg[VW-1:0]];
                if (idx_reg < ch_cnt_reg)
                begin
                    state_next = S_ADD_WB;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_ADD_WB:
            begin
                ref_addr  = ch_keys_reg[idx_reg[VW-1:0]];
                ref_we    = 1'b1;
                ref_wdata = (ref_val == REF_MAX) ? REF_MAX : ref_val + REF_W'(1);
                if (ref_val == '0)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_ON;
                    emit_key  = ref_addr;
                    emit_str  = ch_strs_reg[idx_reg[VW-1:0]];
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_ADD_RD;
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Staging of results: a new one pushes out the pending one.
    always_comb
    begin
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        pend_key_next  = pend_key_reg;
        pend_str_next  = pend_str_reg;
        rv_next        = 1'b0;
        ok_next        = pend_kind_reg;
        okey_next      = pend_key_reg;
        ostr_next      = pend_str_reg;
        last_next      = 1'b0;
        if (emit)
        begin
            rv_next        = pend_reg;
            pend_next      = 1'b1;
            pend_kind_next = emit_kind;
            pend_key_next  = emit_key;
            pend_str_next  = emit_str;
        end
        else if (state_reg == S_FLUSH)
        begin
            rv_next   = pend_reg;
            last_next = 1'b1;
            pend_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        str_reg       <= str_next;
        tracked_reg   <= tracked_next;
        any_en_reg    <= any_en_next;
        idx_reg       <= idx_next;
        ent_cnt_reg   <= ent_cnt_next;
        ent_keys_reg  <= ent_keys_next;
        ch_cnt_reg    <= ch_cnt_next;
        ch_keys_reg   <= ch_keys_next;
        ch_strs_reg   <= ch_strs_next;
        pend_kind_reg <= pend_kind_next;
        pend_key_reg  <= pend_key_next;
        pend_str_reg  <= pend_str_next;
        ok_reg        <= ok_next;
        okey_reg      <= okey_next;
        ostr_reg      <= ostr_next;
        last_reg      <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign out_kind     = ok_reg;
    assign out_key      = okey_reg;
    assign out_strength = ostr_reg;
    assign last         = last_reg;

    // A clear command produces no result.
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_CLEAR) |=> !result_valid)
        else $error("result after clear command");

    // The final result of an item is never followed directly by another.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result directly after last");

    // Note-offs carry zero strength.
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_kind == KIND_OFF) |-> (out_strength == '0))
        else $error("note-off with strength");

endmodule

>>> rtl/mce_vmem.sv
// Synchronous memory with registered reads and per-entry valid bits.
module mce_vmem
    import mce_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = NOTE_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear_all,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic                     wvalid,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    output logic                     rvalid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    // Storage array, written and read at one address each.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Valid bits, cleared at once by reset or a clear command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= wvalid;
            end
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule
